/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check of prop on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/ffa_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_pkg: shared types and codes
// Operation and status codes, sequencer states of the free-region allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] region_address;
      logic [31:0] region_size;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [1:0]  status;
      logic [8:0]  records_in_use;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,     // read entry idx, compare when data returns
      S_SCANCHK,
      S_PREV,     // read entry pos-1 for free
      S_PREVCHK,
      S_SHDN,     // shift entries down (delete)
      S_SHDNW,
      S_SHUP,     // shift entries up (insert)
      S_SHUPW,
      S_RESP
   } state_type;

endpackage

/* rtl/ffa_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_if: valid/ready channel
// Carries one payload of type T with a valid/ready transfer handshake.
// ---------------------------------------------------------------------------
interface ffa_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/ffa_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_table: region record memory
// One-port-write, one-port-read synchronous memory of start/length pairs.
// ---------------------------------------------------------------------------
module ffa_table #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);
   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/first_fit_free_list_allocator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_top: first-fit allocator with coalescing
// Address-sorted table of free regions in one synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   req carries operation, region_address and region_size; rsp returns
//   granted_address, status and records_in_use, one result per request.
//   One request is worked at a time. The sequencer scans the record memory
//   record by record (read in S_SCAN, then compare on the registered data
//   in S_SCANCHK). A delete shifts the records behind the hit down and an
//   insert shifts them up, each record moved by a read state and a write
//   state. Clear only resets the record count before the response.
//   Reset empties the table at once; the memory is not cleared, since only
//   records below the count are ever used.
//   The result waits in an output register while rsp_ready is low; the
//   next request is taken only after that result has been transferred.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module first_fit_free_list_allocator_top #(
   parameter int MAX_RECORDS = 256
) (
   input  logic clock,
   input  logic reset,
   ffa_if.sink   req,
   ffa_if.source rsp
);
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_RECORDS);

   ffa_pkg::state_type state_ff, state_in;
   ffa_pkg::req_type   cur_ff, cur_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;     // scan position / shift pointer
   logic [CW-1:0] pos_ff, pos_in;     // hit or insertion point
   logic [CW-1:0] end_ff, end_in;     // shift bound
   logic [63:0]   hold_ff, hold_in;   // record to write at end of shift
   logic [63:0]   nxt_ff, nxt_in;     // record at pos for free
   logic          hasnxt_ff, hasnxt_in;
   logic          vld_ff, vld_in;
   ffa_pkg::rsp_type out_ff, out_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;

   ffa_table #(.DEPTH(MAX_RECORDS), .AW(AW)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [31:0] r_start, r_len, f_end;
   assign r_start = rd_data[63:32];
   assign r_len   = rd_data[31:0];
   assign f_end   = cur_ff.region_address + cur_ff.region_size;

   assign req.ready   = (state_ff == ffa_pkg::S_IDLE) && !vld_ff;
   assign rsp.valid   = vld_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      end_ff    <= end_in;
      hold_ff   <= hold_in;
      nxt_ff    <= nxt_in;
      hasnxt_ff <= hasnxt_in;
      out_ff    <= out_in;
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      end_in    = end_ff;
      hold_in   = hold_ff;
      nxt_in    = nxt_ff;
      hasnxt_in = hasnxt_ff;
      out_in    = out_ff;
      vld_in    = vld_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = hold_ff;
      rd_addr   = idx_ff[AW-1:0];
      if (vld_ff && rsp.ready) begin
         vld_in = 1'b0;
      end
      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               cur_in = req.payload;
               idx_in = '0;
               out_in.granted_address = '0;
               out_in.status = ffa_pkg::ST_OK;
               hasnxt_in = 1'b0;
               unique case (req.payload.operation)
                  ffa_pkg::OP_ALLOC, ffa_pkg::OP_FREE: state_in = ffa_pkg::S_SCAN;
                  ffa_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                     state_in = ffa_pkg::S_RESP;
                  end
                  default: state_in = ffa_pkg::S_RESP;
               endcase
            end
         end
         ffa_pkg::S_SCAN: begin
            if (idx_ff >= cnt_ff) begin
               // Ran off the end of the table.
               pos_in = idx_ff;
               if (cur_ff.operation == ffa_pkg::OP_ALLOC) begin
                  out_in.status = ffa_pkg::ST_OOM;
                  state_in = ffa_pkg::S_RESP;
               end else begin
                  state_in = ffa_pkg::S_PREV;
               end
            end else begin
               state_in = ffa_pkg::S_SCANCHK;
            end
         end
         ffa_pkg::S_SCANCHK: begin
            if (cur_ff.operation == ffa_pkg::OP_ALLOC) begin
               if (r_len >= cur_ff.region_size) begin
                  out_in.granted_address = r_start;
                  pos_in = idx_ff;
                  if (r_len == cur_ff.region_size) begin
                     cnt_in = cnt_ff - 1'b1;
                     idx_in = idx_ff;
                     end_in = cnt_ff - 1'b1;
                     state_in = ffa_pkg::S_SHDN;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = {r_start + cur_ff.region_size,
                                r_len - cur_ff.region_size};
                     state_in = ffa_pkg::S_RESP;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ffa_pkg::S_SCAN;
               end
            end else if (r_start > cur_ff.region_address) begin
               pos_in = idx_ff;
               nxt_in = rd_data;
               hasnxt_in = 1'b1;
               state_in = ffa_pkg::S_PREV;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ffa_pkg::S_SCAN;
            end
         end
         ffa_pkg::S_PREV: begin
            idx_in = pos_ff - 1'b1;
            rd_addr = pos_ff[AW-1:0] - 1'b1;
            state_in = ffa_pkg::S_PREVCHK;
         end
         ffa_pkg::S_PREVCHK: begin
            if (pos_ff != '0 && (r_start + r_len) == cur_ff.region_address) begin
               if (hasnxt_ff && f_end == nxt_ff[63:32]) begin
                  // Merge both sides; the following record is removed.
                  hold_in = {r_start, r_len + cur_ff.region_size + nxt_ff[31:0]};
                  wr_en = 1'b1;
                  wr_addr = pos_ff[AW-1:0] - 1'b1;
                  wr_data = {r_start, r_len + cur_ff.region_size + nxt_ff[31:0]};
                  cnt_in = cnt_ff - 1'b1;
                  idx_in = pos_ff;
                  end_in = cnt_ff - 1'b1;
                  state_in = ffa_pkg::S_SHDN;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = pos_ff[AW-1:0] - 1'b1;
                  wr_data = {r_start, r_len + cur_ff.region_size};
                  state_in = ffa_pkg::S_RESP;
               end
            end else if (hasnxt_ff && f_end == nxt_ff[63:32]) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = {cur_ff.region_address, nxt_ff[31:0] + cur_ff.region_size};
               state_in = ffa_pkg::S_RESP;
            end else if (cnt_ff < MAXC) begin
               hold_in = {cur_ff.region_address, cur_ff.region_size};
               idx_in = cnt_ff;
               cnt_in = cnt_ff + 1'b1;
               state_in = ffa_pkg::S_SHUP;
            end else begin
               out_in.status = ffa_pkg::ST_FULL;
               state_in = ffa_pkg::S_RESP;
            end
         end
         ffa_pkg::S_SHDN: begin
            // Move record idx+1 down to idx until idx reaches the new count.
            if (idx_ff >= end_ff) begin
               state_in = ffa_pkg::S_RESP;
            end else begin
               rd_addr = idx_ff[AW-1:0] + 1'b1;
               state_in = ffa_pkg::S_SHDNW;
            end
         end
         ffa_pkg::S_SHDNW: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            idx_in = idx_ff + 1'b1;
            state_in = ffa_pkg::S_SHDN;
         end
         ffa_pkg::S_SHUP: begin
            // Move record idx-1 up to idx, then drop the new record at pos.
            if (idx_ff <= pos_ff) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               state_in = ffa_pkg::S_RESP;
            end else begin
               rd_addr = idx_ff[AW-1:0] - 1'b1;
               state_in = ffa_pkg::S_SHUPW;
            end
         end
         ffa_pkg::S_SHUPW: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            idx_in = idx_ff - 1'b1;
            state_in = ffa_pkg::S_SHUP;
         end
         ffa_pkg::S_RESP: begin
            if (!vld_ff || rsp.ready) begin
               out_in.records_in_use = 9'(cnt_ff);
               vld_in = 1'b1;
               state_in = ffa_pkg::S_IDLE;
            end
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase
   end

   `ASSERT_CLK(a_cnt_max, clock, reset, cnt_ff <= MAXC, "record count above capacity")
   `ASSERT_CLK(a_no_accept_busy, clock, reset,
      (state_ff != ffa_pkg::S_IDLE) |-> !req.ready, "request taken while busy")
   `ASSERT_CLK(a_write_in_range, clock, reset,
      wr_en |-> (wr_addr < MAXC), "memory write beyond capacity")
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)), "result dropped")
endmodule
